@@ rtl/lpht_pkg.sv @@
// Shared types and constants for the linear probing hash table.
package lpht_pkg;

  localparam int OpW       = 2;
  localparam int KeyPortW  = 32;
  localparam int ValPortW  = 32;
  localparam int SlotOutW  = 6;
  localparam int CountOutW = 7;
  localparam int InTdataW  = 72;
  localparam int OutTdataW = 48;

  typedef enum logic [1:0] {
    OP_FIND   = 2'd0,
    OP_INSERT = 2'd1,
    OP_REMOVE = 2'd2,
    OP_CLEAR  = 2'd3
  } op_e;

  typedef enum logic [1:0] {
    ST_OK      = 2'd0,
    ST_ABSENT  = 2'd1,
    ST_UPDATED = 2'd2,
    ST_FULL    = 2'd3
  } status_e;

  typedef enum logic [1:0] {
    BK_IDLE  = 2'd0,
    BK_ISSUE = 2'd1,
    BK_CHECK = 2'd2,
    BK_DONE  = 2'd3
  } bk_state_e;

  typedef struct packed {
    status_e                status;
    logic [ValPortW-1:0]    value_out;
    logic [SlotOutW-1:0]    slot_index;
    logic [CountOutW-1:0]   entry_count;
  } result_t;

endpackage

@@ rtl/linear_probe_hash_table.sv @@
// Linear probing key/value table: a find, insert or remove probes slots in turn, where
// one slot is probed per cycle through the key and value memory read port, and a clear
// skips the probe; for a table size that is not a power of two the front end reduces
// the key to its home slot four key bits at a time, overlapped with the previous item
// through a two-entry queue.
module linear_probe_hash_table #(
  parameter int TABLE_SIZE = 64,
  parameter int KEY_BITS   = 32,
  parameter int VALUE_BITS = 32
) (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  input  logic                           s_axis_tvalid,
  output logic                           s_axis_tready,
  // Fields from bit 0: opcode[1:0], key[33:2], value[65:34], zero fill.
  input  logic [lpht_pkg::InTdataW-1:0]  s_axis_tdata,
  output logic                           m_axis_tvalid,
  input  logic                           m_axis_tready,
  // Fields from bit 0: status[1:0], value_out[33:2], slot_index[39:34],
  // entry_count[46:40], zero fill.
  output logic [lpht_pkg::OutTdataW-1:0] m_axis_tdata
);
  import lpht_pkg::*;

  localparam int IDXW   = $clog2(TABLE_SIZE);
  localparam int ITEM_W = IDXW + VALUE_BITS + KEY_BITS + OpW;

  logic              fr_valid, fr_ready, bk_valid, bk_ready;
  logic [ITEM_W-1:0] fr_item, bk_item;
  result_t           res;

  lpht_front #(
    .TABLE_SIZE(TABLE_SIZE), .KEY_BITS(KEY_BITS), .VALUE_BITS(VALUE_BITS),
    .IDXW(IDXW), .ITEM_W(ITEM_W)
  ) u_front (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (s_axis_tvalid),
    .in_ready_o  (s_axis_tready),
    .opcode_i    (s_axis_tdata[1:0]),
    .key_i       (s_axis_tdata[33:2]),
    .value_i     (s_axis_tdata[65:34]),
    .out_valid_o (fr_valid),
    .out_ready_i (fr_ready),
    .item_o      (fr_item)
  );

  lpht_fifo #(.WIDTH(ITEM_W), .DEPTH(2)) u_fifo (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .push_valid_i (fr_valid),
    .push_ready_o (fr_ready),
    .push_data_i  (fr_item),
    .pop_valid_o  (bk_valid),
    .pop_ready_i  (bk_ready),
    .pop_data_o   (bk_item)
  );

  lpht_back #(
    .TABLE_SIZE(TABLE_SIZE), .KEY_BITS(KEY_BITS), .VALUE_BITS(VALUE_BITS),
    .IDXW(IDXW), .ITEM_W(ITEM_W)
  ) u_back (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .item_valid_i (bk_valid),
    .item_ready_o (bk_ready),
    .item_i       (bk_item),
    .res_valid_o  (m_axis_tvalid),
    .res_ready_i  (m_axis_tready),
    .res_o        (res)
  );

  assign m_axis_tdata = {1'b0, res.entry_count, res.slot_index, res.value_out, res.status};

`ifndef NO_ASSERTIONS
  a_full_no_slot: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (m_axis_tvalid && res.status == ST_FULL) |-> (res.slot_index == '0 && res.value_out == '0))
    else $error("full result carries a slot or value");

  a_absent_no_data: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (m_axis_tvalid && res.status == ST_ABSENT) |-> (res.slot_index == '0 && res.value_out == '0))
    else $error("absent result carries a slot or value");

  a_queue_handoff: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (fr_valid && !fr_ready) |=> fr_valid)
    else $error("front end dropped an item while the queue was full");
`endif

endmodule

@@ rtl/lpht_front.sv @@
// Front end: takes a beat, works out the home slot and hands the item on.
module lpht_front #(
  parameter int TABLE_SIZE = 64,
  parameter int KEY_BITS   = 32,
  parameter int VALUE_BITS = 32,
  parameter int IDXW       = 6,
  parameter int ITEM_W     = 72
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          in_valid_i,
  output logic                          in_ready_o,
  input  logic [lpht_pkg::OpW-1:0]      opcode_i,
  input  logic [lpht_pkg::KeyPortW-1:0] key_i,
  input  logic [lpht_pkg::ValPortW-1:0] value_i,
  output logic                          out_valid_o,
  input  logic                          out_ready_i,
  output logic [ITEM_W-1:0]             item_o
);
  import lpht_pkg::*;

  localparam bit Pow2  = ((TABLE_SIZE & (TABLE_SIZE - 1)) == 0);
  localparam int Steps = (KEY_BITS + 3) / 4;
  localparam int KeyP  = Steps * 4;
  localparam int StepW = $clog2(Steps + 1);
  localparam logic [IDXW:0] SizeW = (IDXW + 1)'(TABLE_SIZE);

  logic                  busy_q, out_valid_q;
  logic [StepW-1:0]      step_q;
  logic [IDXW-1:0]       rem_q, home_q;
  logic [KeyP-1:0]       sh_q;
  logic [OpW-1:0]        op_q;
  logic [KEY_BITS-1:0]   key_q, key_m;
  logic [VALUE_BITS-1:0] val_q;
  logic [IDXW:0]         r;
  logic                  accept;

  assign key_m      = KEY_BITS'(key_i);
  assign in_ready_o = !busy_q && !out_valid_q;
  assign accept     = in_valid_i && in_ready_o;

  // Remainder by the table size, four key bits per cycle, most significant first.
  always_comb begin
    r = {1'b0, rem_q};
    for (int b = 3; b >= 0; b--) begin
      r = {r[IDXW-1:0], sh_q[KeyP-4+b]};
      if (r >= SizeW) begin
        r = r - SizeW;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q      <= 1'b0;
      out_valid_q <= 1'b0;
      step_q      <= '0;
    end else begin
      if (accept) begin
        if (Pow2) begin
          out_valid_q <= 1'b1;
        end else begin
          busy_q <= 1'b1;
          step_q <= '0;
        end
      end else if (busy_q) begin
        step_q <= step_q + 1'b1;
        if (step_q == StepW'(Steps - 1)) begin
          busy_q      <= 1'b0;
          out_valid_q <= 1'b1;
        end
      end else if (out_valid_q && out_ready_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept) begin
      op_q  <= opcode_i;
      key_q <= key_m;
      val_q <= VALUE_BITS'(value_i);
      rem_q <= '0;
      sh_q  <= KeyP'(key_m);
      if (Pow2) begin
        home_q <= IDXW'(key_m);
      end
    end else if (busy_q) begin
      rem_q <= r[IDXW-1:0];
      sh_q  <= sh_q << 4;
      if (step_q == StepW'(Steps - 1)) begin
        home_q <= r[IDXW-1:0];
      end
    end
  end

  assign out_valid_o = out_valid_q;
  assign item_o      = {home_q, val_q, key_q, op_q};

endmodule

@@ rtl/lpht_fifo.sv @@
// Small queue between the front end and the probe engine.
module lpht_fifo #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 2
) (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             push_valid_i,
  output logic             push_ready_o,
  input  logic [WIDTH-1:0] push_data_i,
  output logic             pop_valid_o,
  input  logic             pop_ready_i,
  output logic [WIDTH-1:0] pop_data_o
);
  localparam int PtrW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CntW = $clog2(DEPTH + 1);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [PtrW-1:0]  wr_q, rd_q;
  logic [CntW-1:0]  cnt_q;
  logic             push, pop;

  assign push_ready_o = (cnt_q != CntW'(DEPTH));
  assign pop_valid_o  = (cnt_q != '0);
  assign push         = push_valid_i && push_ready_o;
  assign pop          = pop_valid_o && pop_ready_i;
  assign pop_data_o   = mem_q[rd_q];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_q  <= '0;
      rd_q  <= '0;
      cnt_q <= '0;
    end else begin
      if (push) begin
        wr_q <= (wr_q == PtrW'(DEPTH - 1)) ? '0 : wr_q + 1'b1;
      end
      if (pop) begin
        rd_q <= (rd_q == PtrW'(DEPTH - 1)) ? '0 : rd_q + 1'b1;
      end
      if (push && !pop) begin
        cnt_q <= cnt_q + 1'b1;
      end else if (pop && !push) begin
        cnt_q <= cnt_q - 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (push) begin
      mem_q[wr_q] <= push_data_i;
    end
  end

endmodule

@@ rtl/lpht_back.sv @@
// Probe engine: walks the slots, updates the table and registers the result.
module lpht_back #(
  parameter int TABLE_SIZE = 64,
  parameter int KEY_BITS   = 32,
  parameter int VALUE_BITS = 32,
  parameter int IDXW       = 6,
  parameter int ITEM_W     = 72
) (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  item_valid_i,
  output logic                  item_ready_o,
  input  logic [ITEM_W-1:0]     item_i,
  output logic                  res_valid_o,
  input  logic                  res_ready_i,
  output lpht_pkg::result_t     res_o
);
  import lpht_pkg::*;

  localparam int CntW = $clog2(TABLE_SIZE + 1);

  bk_state_e state_q, state_d;

  logic [KEY_BITS-1:0]   key_mem [TABLE_SIZE];
  logic [VALUE_BITS-1:0] val_mem [TABLE_SIZE];

  logic [TABLE_SIZE-1:0] present_q, tomb_q;
  logic [CntW-1:0]       live_q, nprobe_q;
  op_e                   op_q;
  logic [KEY_BITS-1:0]   key_q, rd_key_q;
  logic [VALUE_BITS-1:0] val_q, rd_val_q;
  logic [IDXW-1:0]       pos_q, chk_pos_q, free_q, hit_pos_q;
  logic                  have_free_q, hit_q;
  result_t               res_q;
  logic                  res_valid_q;

  // Item fields.
  logic [1:0]            in_op;
  logic [KEY_BITS-1:0]   in_key;
  logic [VALUE_BITS-1:0] in_val;
  logic [IDXW-1:0]       in_home;
  assign {in_home, in_val, in_key, in_op} = item_i;

  // Per-probe decisions.
  logic pres, tomb, match, is_empty, stop, have_free_d;
  logic [IDXW-1:0] free_d, pos_next;
  logic out_free;

  // Completion actions.
  logic                  key_we, val_we;
  logic [IDXW-1:0]       val_wa;
  logic [TABLE_SIZE-1:0] present_d, tomb_d;
  logic [CntW-1:0]       live_d;
  result_t               res_d;

  assign pres     = present_q[chk_pos_q];
  assign tomb     = tomb_q[chk_pos_q];
  assign match    = pres && (rd_key_q == key_q);
  assign is_empty = !pres && !tomb;
  assign stop     = is_empty || match || (nprobe_q == CntW'(TABLE_SIZE));
  assign pos_next = (pos_q == IDXW'(TABLE_SIZE - 1)) ? '0 : pos_q + 1'b1;
  assign out_free = !res_valid_q || res_ready_i;

  always_comb begin
    have_free_d = have_free_q;
    free_d      = free_q;
    if (op_q == OP_INSERT && !pres && !have_free_q) begin
      have_free_d = 1'b1;
      free_d      = chk_pos_q;
    end
  end

  always_comb begin
    state_d = state_q;
    case (state_q)
      BK_IDLE: begin
        if (item_valid_i) begin
          state_d = (op_e'(in_op) == OP_CLEAR) ? BK_DONE : BK_ISSUE;
        end
      end
      BK_ISSUE: state_d = BK_CHECK;
      BK_CHECK: begin
        if (stop) begin
          state_d = BK_DONE;
        end
      end
      BK_DONE: begin
        if (out_free) begin
          state_d = BK_IDLE;
        end
      end
      default: state_d = BK_IDLE;
    endcase
  end

  always_comb begin
    key_we    = 1'b0;
    val_we    = 1'b0;
    val_wa    = free_q;
    present_d = present_q;
    tomb_d    = tomb_q;
    live_d    = live_q;
    res_d     = '{status: ST_OK, value_out: '0, slot_index: '0, entry_count: '0};
    if (state_q == BK_DONE) begin
      case (op_q)
        OP_FIND: begin
          if (hit_q) begin
            res_d.value_out  = ValPortW'(rd_val_q);
            res_d.slot_index = SlotOutW'(hit_pos_q);
          end else begin
            res_d.status = ST_ABSENT;
          end
        end
        OP_INSERT: begin
          if (hit_q) begin
            res_d.status = ST_UPDATED;
            val_we       = 1'b1;
            if (have_free_q) begin
              // Pull the entry forward into the earlier tombstone.
              key_we             = 1'b1;
              present_d[free_q]  = 1'b1;
              tomb_d[free_q]     = 1'b0;
              present_d[hit_pos_q] = 1'b0;
              tomb_d[hit_pos_q]    = 1'b1;
              res_d.slot_index   = SlotOutW'(free_q);
            end else begin
              val_wa           = hit_pos_q;
              res_d.slot_index = SlotOutW'(hit_pos_q);
            end
          end else if (have_free_q) begin
            key_we            = 1'b1;
            val_we            = 1'b1;
            present_d[free_q] = 1'b1;
            tomb_d[free_q]    = 1'b0;
            live_d            = live_q + 1'b1;
            res_d.slot_index  = SlotOutW'(free_q);
          end else begin
            res_d.status = ST_FULL;
          end
        end
        OP_REMOVE: begin
          if (hit_q) begin
            present_d[hit_pos_q] = 1'b0;
            tomb_d[hit_pos_q]    = 1'b1;
            live_d               = live_q - 1'b1;
          end else begin
            res_d.status = ST_ABSENT;
          end
        end
        OP_CLEAR: begin
          present_d = '0;
          tomb_d    = '0;
          live_d    = '0;
        end
        default: res_d.status = ST_OK;
      endcase
    end
    res_d.entry_count = CountOutW'(live_d);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= BK_IDLE;
      present_q   <= '0;
      tomb_q      <= '0;
      live_q      <= '0;
      res_valid_q <= 1'b0;
    end else begin
      state_q <= state_d;
      if (res_valid_q && res_ready_i) begin
        res_valid_q <= 1'b0;
      end
      if (state_q == BK_DONE && out_free) begin
        present_q   <= present_d;
        tomb_q      <= tomb_d;
        live_q      <= live_d;
        res_valid_q <= 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    case (state_q)
      BK_IDLE: begin
        op_q        <= op_e'(in_op);
        key_q       <= in_key;
        val_q       <= in_val;
        pos_q       <= in_home;
        nprobe_q    <= '0;
        have_free_q <= 1'b0;
        free_q      <= '0;
        hit_q       <= 1'b0;
      end
      BK_ISSUE: begin
        rd_key_q  <= key_mem[pos_q];
        rd_val_q  <= val_mem[pos_q];
        chk_pos_q <= pos_q;
        pos_q     <= pos_next;
        nprobe_q  <= nprobe_q + 1'b1;
      end
      BK_CHECK: begin
        have_free_q <= have_free_d;
        free_q      <= free_d;
        if (stop) begin
          hit_q     <= match;
          hit_pos_q <= chk_pos_q;
        end else begin
          rd_key_q  <= key_mem[pos_q];
          rd_val_q  <= val_mem[pos_q];
          chk_pos_q <= pos_q;
          pos_q     <= pos_next;
          nprobe_q  <= nprobe_q + 1'b1;
        end
      end
      BK_DONE: begin
        if (out_free) begin
          res_q <= res_d;
          if (key_we) begin
            key_mem[free_q] <= key_q;
          end
          if (val_we) begin
            val_mem[val_wa] <= val_q;
          end
        end
      end
      default: ;
    endcase
  end

  assign item_ready_o = (state_q == BK_IDLE);
  assign res_valid_o  = res_valid_q;
  assign res_o        = res_q;

endmodule
